### hw/rtl/sorted_max_priority_queue_unit_macros.svh
// assertion macros shared by the checker
`ifndef SORTED_MAX_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_MAX_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SMPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/smpq_pkg.sv
`default_nettype none
package smpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 5;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OUT_W   = STAT_W + VALUE_W + OCC_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic                      en;
    logic                      pop;
    logic signed [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage
`default_nettype wire

### hw/rtl/smpq_cell.sv
`default_nettype none
module smpq_cell (
  input  wire logic                              clk,
  input  wire smpq_pkg::cell_cmd_t               cmd,
  input  wire logic                              valid_i,
  input  wire logic                              left_ge,
  input  wire logic signed [smpq_pkg::VALUE_W-1:0] left_data,
  input  wire logic signed [smpq_pkg::VALUE_W-1:0] right_data,
  output logic                                   ge_o,
  output logic signed [smpq_pkg::VALUE_W-1:0]    data_o
);
  import smpq_pkg::*;

  logic signed [VALUE_W-1:0] data_r;
  logic signed [VALUE_W-1:0] data_nxt;

  // entry stays ahead of the new value
  assign ge_o   = valid_i && (data_r >= cmd.value);
  assign data_o = data_r;

  always_comb begin
    data_nxt = data_r;
    if (cmd.en) begin
      if (cmd.pop) begin
        data_nxt = right_data;
      end else if (!left_ge) begin
        data_nxt = left_data;
      end else if (!ge_o) begin
        data_nxt = cmd.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/sorted_max_priority_queue_unit.sv
// Max-first priority queue of up to DEPTH signed 32-bit values, kept sorted in
// a chain of cells with the largest value in cell 0. Each input item is an
// insert (tuser 0) or a pop of the largest value (tuser 1) and gives one result
// item with status, popped value and occupancy. The cells compare against the
// new value in parallel and shift in one step, and the result sits in an
// output register, so an item can be taken every cycle while the result side
// keeps up. The cfg write sets the capacity (reset 16, limited to DEPTH); it is
// taken at any time but is meant to be written while no item is in flight.
`default_nettype none
module sorted_max_priority_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [smpq_pkg::VALUE_W-1:0]        in_tdata,   // value
  input  wire logic                                in_tuser,   // req_type
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // status [1:0], popped_value [33:2], occupancy [38:34], zero pad
  output logic [smpq_pkg::OUT_TDATA_W-1:0]         out_tdata,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [smpq_pkg::CFG_W-1:0]          cfg_data
);
  import smpq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0] cap_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [OUT_TDATA_W-1:0] out_tdata_nxt;

  logic      accept;
  logic      full;
  logic      empty;
  status_t   status;
  cell_cmd_t cmd;

  logic                      cell_valid [DEPTH];
  logic                      cell_ge    [DEPTH];
  logic signed [VALUE_W-1:0] cell_data  [DEPTH];

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_tvalid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign full  = (XW'(count_r) >= XW'(cap_r)) || (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    status    = ST_DONE;
    count_nxt = count_r;
    cmd.en    = 1'b0;
    cmd.pop   = (in_tuser == REQ_POP);
    cmd.value = in_tdata;
    if (in_tuser == REQ_POP) begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        cmd.en    = accept;
        count_nxt = count_r - CW'(1);
      end
    end else begin
      if (full) begin
        status = ST_FULL;
      end else begin
        cmd.en    = accept;
        count_nxt = count_r + CW'(1);
      end
    end
    out_tdata_nxt = '0;
    out_tdata_nxt[STAT_W-1:0] = status;
    if (status == ST_DONE && in_tuser == REQ_POP) begin
      out_tdata_nxt[STAT_W+VALUE_W-1:STAT_W] = cell_data[0];
    end
    out_tdata_nxt[OUT_W-1:STAT_W+VALUE_W] = OCC_W'(count_nxt);
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign cell_valid[gi] = (count_r > CW'(gi));
      if (gi == 0) begin : g_head
        smpq_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .valid_i    (cell_valid[gi]),
          .left_ge    (1'b1),
          .left_data  (cmd.value),
          .right_data (cell_data[gi+1]),
          .ge_o       (cell_ge[gi]),
          .data_o     (cell_data[gi])
        );
      end else if (gi == DEPTH - 1) begin : g_tail
        smpq_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .valid_i    (cell_valid[gi]),
          .left_ge    (cell_ge[gi-1]),
          .left_data  (cell_data[gi-1]),
          .right_data ('0),
          .ge_o       (cell_ge[gi]),
          .data_o     (cell_data[gi])
        );
      end else begin : g_mid
        smpq_cell u_cell (
          .clk        (clk),
          .cmd        (cmd),
          .valid_i    (cell_valid[gi]),
          .left_ge    (cell_ge[gi-1]),
          .left_data  (cell_data[gi-1]),
          .right_data (cell_data[gi+1]),
          .ge_o       (cell_ge[gi]),
          .data_o     (cell_data[gi])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/smpq_checker.sv
`default_nettype none
`include "sorted_max_priority_queue_unit_macros.svh"
module smpq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [smpq_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import smpq_pkg::*;

  logic [STAT_W-1:0]  chk_status;
  logic [VALUE_W-1:0] chk_popped;
  logic [OCC_W-1:0]   chk_occ;

  assign chk_status = out_tdata[STAT_W-1:0];
  assign chk_popped = out_tdata[STAT_W+VALUE_W-1:STAT_W];
  assign chk_occ    = out_tdata[OUT_W-1:STAT_W+VALUE_W];

  `SMPQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "result item changed while stalled")
  `SMPQ_ASSERT_NEXT(a_accept_result, in_tvalid && in_tready,
    out_tvalid, "accepted item gave no result item")
  `SMPQ_ASSERT_NOW(a_status_code, out_tvalid,
    chk_status == ST_DONE || chk_status == ST_FULL || chk_status == ST_EMPTY,
    "unknown status code")
  `SMPQ_ASSERT_NOW(a_fail_no_value, out_tvalid && chk_status != ST_DONE,
    chk_popped == '0, "failed item carries a popped value")
  `SMPQ_ASSERT_NOW(a_empty_occ, out_tvalid && chk_status == ST_EMPTY,
    chk_occ == '0, "empty status with nonzero occupancy")

endmodule

bind sorted_max_priority_queue_unit smpq_checker u_smpq_checker (.*);
`default_nettype wire

### dv/tb_top.sv
`default_nettype none
module tb_top;
  import smpq_pkg::*;

  localparam int QDEPTH = 16;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] popped;
    logic [OCC_W-1:0]          occ;
  } pq_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [VALUE_W-1:0]     in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;

  // queue model and results still owed by the block
  logic signed [VALUE_W-1:0] model_entries[$];
  logic [CFG_W-1:0]          model_capacity;
  pq_result_t                pending_results[$];

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;

  sorted_max_priority_queue_unit #(
    .DEPTH(QDEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic pq_result_t queue_model_step(req_t req, logic signed [VALUE_W-1:0] val);
    pq_result_t res;
    int         limit;
    int         pos;
    res.status = ST_DONE;
    res.popped = '0;
    limit = (model_capacity > QDEPTH) ? QDEPTH : int'(model_capacity);
    if (req == REQ_INSERT) begin
      if (model_entries.size() >= limit) begin
        res.status = ST_FULL;
      end else begin
        pos = model_entries.size();
        // equal values land behind the ones already held
        for (int i = 0; i < model_entries.size(); i++) begin
          if (model_entries[i] < val) begin
            pos = i;
            break;
          end
        end
        model_entries.insert(pos, val);
      end
    end else begin
      if (model_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.popped = model_entries.pop_front();
      end
    end
    res.occ = OCC_W'(model_entries.size());
    return res;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return $signed($urandom_range(6)) - 3;
      1: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic issue_request(req_t req, logic signed [VALUE_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(queue_model_step(req, val));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] cap);
    drain_results();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_capacity = cap;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 26; recv_stall_pct = 26; end
    endcase
  endtask

  task automatic test_empty_pop();
    issue_request(REQ_POP, 32'sd0);
  endtask

  task automatic test_extremes_and_ties();
    issue_request(REQ_INSERT, 32'sh7FFF_FFFF);
    issue_request(REQ_INSERT, 32'sh8000_0000);
    issue_request(REQ_INSERT, 32'sd0);
    issue_request(REQ_INSERT, -32'sd1);
    issue_request(REQ_INSERT, 32'sd7);
    issue_request(REQ_INSERT, 32'sd7);
    repeat (6) issue_request(REQ_POP, 32'sh5A5A_5A5A);
  endtask

  task automatic test_capacity_edges();
    write_capacity(5'd1);
    issue_request(REQ_INSERT, 32'sd42);
    issue_request(REQ_INSERT, 32'sd43);
    issue_request(REQ_POP, 32'sd0);
    write_capacity(5'd0);
    issue_request(REQ_INSERT, 32'sd1);
    issue_request(REQ_POP, 32'sd0);
  endtask

  task automatic test_capacity_shrink();
    write_capacity(5'd16);
    issue_request(REQ_INSERT, 32'sd10);
    issue_request(REQ_INSERT, -32'sd20);
    issue_request(REQ_INSERT, 32'sd30);
    write_capacity(5'd2);
    issue_request(REQ_INSERT, 32'sd5);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_POP, 32'sd0);
    issue_request(REQ_INSERT, 32'sd5);
  endtask

  task automatic test_backpressure();
    write_capacity(5'd16);
    set_idling(0);
    @(posedge clk);
    hold_cycles = 150;
    for (int i = 0; i < 30; i++) begin
      issue_request(($urandom_range(99) < 60) ? REQ_INSERT : REQ_POP, pick_value());
    end
  endtask

  task automatic test_random_traffic(int per_phase);
    logic [CFG_W-1:0] cap_list[8];
    int               insert_pct;
    cap_list = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16};
    cap_list[7] = CFG_W'($urandom_range(1, 16));
    for (int phase = 0; phase < 8; phase++) begin
      write_capacity(cap_list[phase]);
      set_idling(phase % 4);
      case (phase % 3)
        0: insert_pct = 70;
        1: insert_pct = 35;
        default: insert_pct = 55;
      endcase
      for (int i = 0; i < per_phase; i++) begin
        issue_request(($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_POP, pick_value());
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pq_result_t want;
    pq_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = status_t'(out_tdata[1:0]);
      got.popped = out_tdata[33:2];
      got.occ    = out_tdata[38:34];
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t unexpected item: status %0d popped %0d occupancy %0d",
                 $time, got.status, got.popped, got.occ);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          error_count++;
          $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.popped != want.popped) begin
          error_count++;
          $display("%0t popped_value expected %0d actual %0d", $time, want.popped, got.popped);
        end
        if (got.occ != want.occ) begin
          error_count++;
          $display("%0t occupancy expected %0d actual %0d", $time, want.occ, got.occ);
        end
      end
    end
  end

  initial begin
    #(12 * 600000);
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    error_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    model_capacity = CAP_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_pop();
    test_extremes_and_ties();
    test_capacity_edges();
    test_capacity_shrink();
    test_backpressure();
    test_random_traffic(175);

    drain_results();
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_max_priority_queue_unit.sv
hw/rtl/smpq_checker.sv
dv/tb_top.sv
